FILE: rtl/d4_flow_direction_route_interval_core_defines.svh
// Assertion macros shared by the flow direction core.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef D4_FLOW_DIRECTION_ROUTE_INTERVAL_CORE_DEFINES_SVH
`define D4_FLOW_DIRECTION_ROUTE_INTERVAL_CORE_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define D4FD_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define D4FD_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: rtl/d4fd_pkg.sv
// Shared types and constants for the D4 flow direction and routing interval core.
// No dependencies; used by the top level, front end, queue and back end.
`timescale 1ns / 1ps

package d4fd_pkg;

    localparam int FRAC_BITS_DEF = 10;
    localparam int ELEV_W        = 32;
    localparam int SPACE_W       = 24;
    localparam int SPEED_W       = 16;
    localparam int INTV_W        = 32;
    localparam int DIR_W         = 3;
    localparam int MASK_W        = 4;
    localparam int DATA_W        = 32;
    localparam int ADDR_W        = 5;
    localparam int REG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_PTR_W   = 1;
    localparam int QUEUE_CNT_W   = 2;

    localparam logic [DIR_W-1:0] DIR_SELF  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_NORTH = 3'd1;
    localparam logic [DIR_W-1:0] DIR_EAST  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_SOUTH = 3'd3;
    localparam logic [DIR_W-1:0] DIR_WEST  = 3'd4;

    localparam logic [REG_IDX_W-1:0] REG_SPEED   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SLOPE   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_LATLONG = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_GRID    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_SUBGRID = 3'd4;

    localparam logic [SPEED_W-1:0] SPEED_RST = 16'd102;
    localparam logic [SPACE_W-1:0] GRID_RST  = 24'd10240;
    localparam logic [INTV_W-1:0]  INTV_MAX  = 32'hFFFF_FFFF;

    // Settings the front end needs to classify a cell.
    typedef struct packed {
        logic               latlong;
        logic               subgrid;
        logic [SPACE_W-1:0] grid;
    } t_class_cfg;

    // Settings the back end needs to compute the interval.
    typedef struct packed {
        logic               slope;
        logic [SPEED_W-1:0] speed;
    } t_route_cfg;

    typedef struct packed {
        logic               cell_valid;
        logic [DIR_W-1:0]   dir;
        logic               force_zero;
        logic [SPACE_W-1:0] spacing;
    } t_meta;

    localparam int META_W = $bits(t_meta);

    typedef struct packed {
        t_meta             meta;
        logic [ELEV_W-1:0] drop;
    } t_item;

endpackage

FILE: rtl/d4_flow_direction_route_interval_core.sv
// Top level of the D4 flow direction and routing interval core: APB registers,
// front end, request queue and arithmetic back end. Depends on d4fd_pkg and all d4fd_* modules.
`timescale 1ns / 1ps

// One cell request is taken per clock while busy is low, and one result follows
// per request on o_done, in request order. The back end is built from pipelines:
// the slope divider, the square root and the interval divider each spend one
// stage per result bit. Results are shown for a single cycle and cannot be held
// off, so the receiver must take every o_done pulse.
// Registers may only be written while no request is in flight.
module d4_flow_direction_route_interval_core #(
    parameter int FRAC_BITS = d4fd_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [d4fd_pkg::ADDR_W-1:0]        paddr,
    input  logic [d4fd_pkg::DATA_W-1:0]        pwdata,
    output logic [d4fd_pkg::DATA_W-1:0]        prdata,
    output logic                               pready,
    input  logic                               start,
    output logic                               busy,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_center,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_north,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_east,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_south,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_west,
    input  logic [d4fd_pkg::MASK_W-1:0]        i_neighbor_mask,
    input  logic                               i_center_nodata,
    input  logic [d4fd_pkg::SPACE_W-1:0]       i_cell_dx,
    input  logic [d4fd_pkg::SPACE_W-1:0]       i_cell_dy,
    input  logic                               i_channel_present,
    input  logic                               i_boundary_hold,
    output logic                               o_done,
    output logic                               o_cell_valid,
    output logic [d4fd_pkg::DIR_W-1:0]         o_direction,
    output logic [d4fd_pkg::INTV_W-1:0]        o_route_interval
);

    logic [d4fd_pkg::SPEED_W-1:0]   r_speed;
    logic                           r_slope;
    logic                           r_latlong;
    logic [d4fd_pkg::SPACE_W-1:0]   r_grid;
    logic                           r_subgrid;
    logic                           wr_en;
    logic [d4fd_pkg::REG_IDX_W-1:0] reg_idx;
    d4fd_pkg::t_class_cfg           class_cfg;
    d4fd_pkg::t_route_cfg           route_cfg;
    logic                           q_ready;
    logic                           push;
    d4fd_pkg::t_item                push_item;
    logic                           q_vld;
    d4fd_pkg::t_item                q_item;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[d4fd_pkg::ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed   <= d4fd_pkg::SPEED_RST;
            r_slope   <= 1'b0;
            r_latlong <= 1'b0;
            r_grid    <= d4fd_pkg::GRID_RST;
            r_subgrid <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                d4fd_pkg::REG_SPEED:   r_speed   <= pwdata[d4fd_pkg::SPEED_W-1:0];
                d4fd_pkg::REG_SLOPE:   r_slope   <= pwdata[0];
                d4fd_pkg::REG_LATLONG: r_latlong <= pwdata[0];
                d4fd_pkg::REG_GRID:    r_grid    <= pwdata[d4fd_pkg::SPACE_W-1:0];
                d4fd_pkg::REG_SUBGRID: r_subgrid <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            d4fd_pkg::REG_SPEED:   prdata = d4fd_pkg::DATA_W'(r_speed);
            d4fd_pkg::REG_SLOPE:   prdata = d4fd_pkg::DATA_W'(r_slope);
            d4fd_pkg::REG_LATLONG: prdata = d4fd_pkg::DATA_W'(r_latlong);
            d4fd_pkg::REG_GRID:    prdata = d4fd_pkg::DATA_W'(r_grid);
            d4fd_pkg::REG_SUBGRID: prdata = d4fd_pkg::DATA_W'(r_subgrid);
            default:               prdata = '0;
        endcase
    end

    assign class_cfg.latlong = r_latlong;
    assign class_cfg.subgrid = r_subgrid;
    assign class_cfg.grid    = r_grid;
    assign route_cfg.slope   = r_slope;
    assign route_cfg.speed   = r_speed;

    d4fd_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_start           (start),
        .o_busy            (busy),
        .i_elev_center     (i_elev_center),
        .i_elev_north      (i_elev_north),
        .i_elev_east       (i_elev_east),
        .i_elev_south      (i_elev_south),
        .i_elev_west       (i_elev_west),
        .i_neighbor_mask   (i_neighbor_mask),
        .i_center_nodata   (i_center_nodata),
        .i_cell_dx         (i_cell_dx),
        .i_cell_dy         (i_cell_dy),
        .i_channel_present (i_channel_present),
        .i_boundary_hold   (i_boundary_hold),
        .i_cfg             (class_cfg),
        .i_q_ready         (q_ready),
        .o_push            (push),
        .o_item            (push_item)
    );

    d4fd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_vld   (q_vld),
        .o_item  (q_item)
    );

    d4fd_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_vld            (q_vld),
        .i_item           (q_item),
        .i_cfg            (route_cfg),
        .o_done           (o_done),
        .o_cell_valid     (o_cell_valid),
        .o_direction      (o_direction),
        .o_route_interval (o_route_interval)
    );

endmodule

FILE: rtl/d4fd_front.sv
// Front end: takes a cell request, picks the steepest descent neighbor and spacing.
// Depends on d4fd_pkg; feeds d4fd_queue.
`timescale 1ns / 1ps

module d4fd_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    output logic                               o_busy,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_center,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_north,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_east,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_south,
    input  logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_west,
    input  logic [d4fd_pkg::MASK_W-1:0]        i_neighbor_mask,
    input  logic                               i_center_nodata,
    input  logic [d4fd_pkg::SPACE_W-1:0]       i_cell_dx,
    input  logic [d4fd_pkg::SPACE_W-1:0]       i_cell_dy,
    input  logic                               i_channel_present,
    input  logic                               i_boundary_hold,
    input  d4fd_pkg::t_class_cfg               i_cfg,
    input  logic                               i_q_ready,
    output logic                               o_push,
    output d4fd_pkg::t_item                    o_item
);

    logic                               accept;
    logic                               r_vld;
    logic                               n_vld;
    d4fd_pkg::t_item                    r_item;
    logic                               have_a, have_b, have;
    logic signed [d4fd_pkg::ELEV_W-1:0] best_a, best_b, best;
    logic [d4fd_pkg::DIR_W-1:0]         dir_a, dir_b, dir_pick;
    logic                               descent;
    logic                               force_self;
    logic [d4fd_pkg::ELEV_W:0]          drop_full;
    logic [d4fd_pkg::SPACE_W-1:0]       spacing;
    d4fd_pkg::t_item                    item_c;

    assign o_busy = r_vld & ~i_q_ready;
    assign accept = i_start & ~o_busy;
    assign o_push = r_vld & i_q_ready;
    assign o_item = r_item;

    // Pairwise minimum keeps the earlier direction on equal elevations.
    always_comb begin
        if (i_neighbor_mask[0] && !(i_neighbor_mask[1] && (i_elev_east < i_elev_north))) begin
            have_a = 1'b1;
            best_a = i_elev_north;
            dir_a  = d4fd_pkg::DIR_NORTH;
        end else if (i_neighbor_mask[1]) begin
            have_a = 1'b1;
            best_a = i_elev_east;
            dir_a  = d4fd_pkg::DIR_EAST;
        end else begin
            have_a = 1'b0;
            best_a = i_elev_north;
            dir_a  = d4fd_pkg::DIR_SELF;
        end

        if (i_neighbor_mask[2] && !(i_neighbor_mask[3] && (i_elev_west < i_elev_south))) begin
            have_b = 1'b1;
            best_b = i_elev_south;
            dir_b  = d4fd_pkg::DIR_SOUTH;
        end else if (i_neighbor_mask[3]) begin
            have_b = 1'b1;
            best_b = i_elev_west;
            dir_b  = d4fd_pkg::DIR_WEST;
        end else begin
            have_b = 1'b0;
            best_b = i_elev_south;
            dir_b  = d4fd_pkg::DIR_SELF;
        end

        if (have_a && !(have_b && (best_b < best_a))) begin
            have     = 1'b1;
            best     = best_a;
            dir_pick = dir_a;
        end else begin
            have     = have_b;
            best     = best_b;
            dir_pick = dir_b;
        end
    end

    always_comb begin
        descent    = have && (best < i_elev_center);
        force_self = (i_cfg.subgrid & i_channel_present) | i_boundary_hold;
        drop_full  = {i_elev_center[d4fd_pkg::ELEV_W-1], i_elev_center}
                   - {best[d4fd_pkg::ELEV_W-1], best};

        if (!i_cfg.latlong) begin
            spacing = i_cfg.grid;
        end else if (dir_pick == d4fd_pkg::DIR_NORTH || dir_pick == d4fd_pkg::DIR_SOUTH) begin
            spacing = i_cell_dy;
        end else begin
            spacing = i_cell_dx;
        end

        item_c.meta.cell_valid = ~i_center_nodata;
        item_c.meta.dir        = (i_center_nodata || !descent || force_self)
                               ? d4fd_pkg::DIR_SELF : dir_pick;
        item_c.meta.force_zero = i_center_nodata | ~descent | (spacing == '0);
        item_c.meta.spacing    = spacing;
        item_c.drop            = drop_full[d4fd_pkg::ELEV_W-1:0];
    end

    assign n_vld = accept | (r_vld & ~o_push);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= item_c;
        end
    end

endmodule

FILE: rtl/d4fd_queue.sv
// Two-entry queue between the classifying front end and the arithmetic back end.
// Depends on d4fd_pkg and the shared assertion macros.
`timescale 1ns / 1ps
`include "d4_flow_direction_route_interval_core_defines.svh"

module d4fd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  d4fd_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_vld,
    output d4fd_pkg::t_item o_item
);

    d4fd_pkg::t_item                  r_mem [d4fd_pkg::QUEUE_DEPTH];
    logic [d4fd_pkg::QUEUE_PTR_W-1:0] r_wr, r_rd;
    logic [d4fd_pkg::QUEUE_CNT_W-1:0] r_cnt, n_cnt;
    logic                             pop;

    assign o_ready = r_cnt != d4fd_pkg::QUEUE_CNT_W'(d4fd_pkg::QUEUE_DEPTH);
    assign o_vld   = r_cnt != '0;
    // The back end never stalls, so the head leaves in the cycle it shows.
    assign pop     = o_vld;
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !i_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_wr  <= '0;
            r_rd  <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    `D4FD_ASSERT_ALWAYS(a_cnt_bound, i_clk, i_rst_n, r_cnt <= d4fd_pkg::QUEUE_CNT_W'(d4fd_pkg::QUEUE_DEPTH), "queue count above depth")
    `D4FD_ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, o_ready, "request pushed into a full queue")

endmodule

FILE: rtl/d4fd_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with a sideband carried along.
// Depends on nothing; used twice by d4fd_back.
`timescale 1ns / 1ps

module d4fd_div_pipe #(
    parameter int DW = 52,
    parameter int VW = 24,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    input  logic [SW-1:0] i_side,
    output logic          o_vld,
    output logic [DW-1:0] o_quot,
    output logic [SW-1:0] o_side
);

    logic          r_v   [DW];
    logic [VW-1:0] r_rem [DW];
    logic [DW-1:0] r_acc [DW];
    logic [VW-1:0] r_d   [DW];
    logic [SW-1:0] r_s   [DW];

    genvar k;
    for (k = 0; k < DW; k++) begin : g_stage
        logic          a_v;
        logic [VW-1:0] a_rem;
        logic [DW-1:0] a_acc;
        logic [VW-1:0] a_d;
        logic [SW-1:0] a_s;
        logic [VW:0]   rem_sh;
        logic [VW:0]   rem_sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_v   = i_vld;
            assign a_rem = '0;
            assign a_acc = i_dividend;
            assign a_d   = i_divisor;
            assign a_s   = i_side;
        end else begin : g_next
            assign a_v   = r_v[k-1];
            assign a_rem = r_rem[k-1];
            assign a_acc = r_acc[k-1];
            assign a_d   = r_d[k-1];
            assign a_s   = r_s[k-1];
        end

        // The dividend shifts out of the top while quotient bits shift in below.
        assign rem_sh  = {a_rem, a_acc[DW-1]};
        assign rem_sub = rem_sh - {1'b0, a_d};
        assign ge      = rem_sh >= {1'b0, a_d};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
            r_acc[k] <= {a_acc[DW-2:0], ge};
            r_d[k]   <= a_d;
            r_s[k]   <= a_s;
        end
    end

    assign o_vld  = r_v[DW-1];
    assign o_quot = r_acc[DW-1];
    assign o_side = r_s[DW-1];

endmodule

FILE: rtl/d4fd_sqrt_pipe.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
// Depends on nothing; used by d4fd_back.
`timescale 1ns / 1ps

module d4fd_sqrt_pipe #(
    parameter int XW = 52,
    parameter int SW = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  logic [XW-1:0]    i_radicand,
    input  logic [SW-1:0]    i_side,
    output logic             o_vld,
    output logic [XW/2-1:0]  o_root,
    output logic [SW-1:0]    o_side
);

    localparam int RW = XW / 2;

    logic          r_v    [RW];
    logic [RW:0]   r_rem  [RW];
    logic [RW-1:0] r_root [RW];
    logic [XW-1:0] r_acc  [RW];
    logic [SW-1:0] r_s    [RW];

    genvar k;
    for (k = 0; k < RW; k++) begin : g_stage
        logic          a_v;
        logic [RW:0]   a_rem;
        logic [RW-1:0] a_root;
        logic [XW-1:0] a_acc;
        logic [SW-1:0] a_s;
        logic [RW+2:0] rem_sh;
        logic [RW+2:0] trial;
        logic [RW+2:0] rem_sub;
        logic          ge;

        if (k == 0) begin : g_first
            assign a_v    = i_vld;
            assign a_rem  = '0;
            assign a_root = '0;
            assign a_acc  = i_radicand;
            assign a_s    = i_side;
        end else begin : g_next
            assign a_v    = r_v[k-1];
            assign a_rem  = r_rem[k-1];
            assign a_root = r_root[k-1];
            assign a_acc  = r_acc[k-1];
            assign a_s    = r_s[k-1];
        end

        // Bring down the next bit pair and try the digit one.
        assign rem_sh  = {a_rem, a_acc[XW-1:XW-2]};
        assign trial   = {1'b0, a_root, 2'b01};
        assign ge      = rem_sh >= trial;
        assign rem_sub = rem_sh - trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else begin
                r_v[k] <= a_v;
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[k]  <= ge ? rem_sub[RW:0] : rem_sh[RW:0];
            r_root[k] <= {a_root[RW-2:0], ge};
            r_acc[k]  <= {a_acc[XW-3:0], 2'b00};
            r_s[k]    <= a_s;
        end
    end

    assign o_vld  = r_v[RW-1];
    assign o_root = r_root[RW-1];
    assign o_side = r_s[RW-1];

endmodule

FILE: rtl/d4fd_back.sv
// Back end: slope quotient, square root, speed product and interval divide, one item per cycle.
// Depends on d4fd_pkg, d4fd_div_pipe, d4fd_sqrt_pipe and the shared assertion macros.
`timescale 1ns / 1ps
`include "d4_flow_direction_route_interval_core_defines.svh"

module d4fd_back #(
    parameter int FRAC_BITS = d4fd_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_vld,
    input  d4fd_pkg::t_item                i_item,
    input  d4fd_pkg::t_route_cfg           i_cfg,
    output logic                           o_done,
    output logic                           o_cell_valid,
    output logic [d4fd_pkg::DIR_W-1:0]     o_direction,
    output logic [d4fd_pkg::INTV_W-1:0]    o_route_interval
);

    localparam int Q_W   = d4fd_pkg::ELEV_W + 2 * FRAC_BITS;
    localparam int R_W   = Q_W / 2;
    localparam int DEN_W = d4fd_pkg::SPEED_W + R_W;
    localparam int N_W   = d4fd_pkg::SPACE_W + 2 * FRAC_BITS;
    localparam int S2_W  = d4fd_pkg::META_W + 1;
    localparam logic [R_W-1:0] ONE_ROOT = R_W'(1) << FRAC_BITS;
    localparam logic [N_W-1:0] SAT_LIM  = N_W'(d4fd_pkg::INTV_MAX);

    logic                            q_vld;
    logic [Q_W-1:0]                  q_val;
    logic [d4fd_pkg::META_W-1:0]     q_side;
    logic                            s_vld;
    logic [R_W-1:0]                  s_root;
    logic [d4fd_pkg::META_W-1:0]     s_side;
    logic [R_W-1:0]                  root_sel;
    logic                            r_m_vld;
    logic [DEN_W-1:0]                r_den;
    d4fd_pkg::t_meta                 r_m_meta;
    logic                            d_vld;
    logic [N_W-1:0]                  d_quot;
    logic [S2_W-1:0]                 d_side;
    d4fd_pkg::t_meta                 d_meta;
    logic                            d_den_zero;
    logic [d4fd_pkg::INTV_W-1:0]     interval;
    logic                            r_done;
    logic                            r_cell_valid;
    logic [d4fd_pkg::DIR_W-1:0]      r_dir;
    logic [d4fd_pkg::INTV_W-1:0]     r_interval;

    // drop * 2^(2F) / spacing
    d4fd_div_pipe #(
        .DW (Q_W),
        .VW (d4fd_pkg::SPACE_W),
        .SW (d4fd_pkg::META_W)
    ) u_div_slope (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (i_vld),
        .i_dividend ({i_item.drop, {(2 * FRAC_BITS){1'b0}}}),
        .i_divisor  (i_item.meta.spacing),
        .i_side     (i_item.meta),
        .o_vld      (q_vld),
        .o_quot     (q_val),
        .o_side     (q_side)
    );

    d4fd_sqrt_pipe #(
        .XW (Q_W),
        .SW (d4fd_pkg::META_W)
    ) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (q_vld),
        .i_radicand (q_val),
        .i_side     (q_side),
        .o_vld      (s_vld),
        .o_root     (s_root),
        .o_side     (s_side)
    );

    // Plain routing uses a root of one, which makes the final divide s*2^F/v.
    assign root_sel = i_cfg.slope ? s_root : ONE_ROOT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else begin
            r_m_vld <= s_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_den    <= DEN_W'(i_cfg.speed) * DEN_W'(root_sel);
        r_m_meta <= d4fd_pkg::t_meta'(s_side);
    end

    // spacing * 2^(2F) / (speed * root)
    d4fd_div_pipe #(
        .DW (N_W),
        .VW (DEN_W),
        .SW (S2_W)
    ) u_div_interval (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_vld      (r_m_vld),
        .i_dividend ({r_m_meta.spacing, {(2 * FRAC_BITS){1'b0}}}),
        .i_divisor  (r_den),
        .i_side     ({r_den == '0, r_m_meta}),
        .o_vld      (d_vld),
        .o_quot     (d_quot),
        .o_side     (d_side)
    );

    assign d_meta     = d4fd_pkg::t_meta'(d_side[d4fd_pkg::META_W-1:0]);
    assign d_den_zero = d_side[S2_W-1];

    always_comb begin
        priority if (d_meta.force_zero) begin
            interval = '0;
        end else if (d_den_zero || (d_quot > SAT_LIM)) begin
            interval = d4fd_pkg::INTV_MAX;
        end else begin
            interval = d_quot[d4fd_pkg::INTV_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cell_valid <= d_meta.cell_valid;
        r_dir        <= d_meta.dir;
        r_interval   <= interval;
    end

    assign o_done           = r_done;
    assign o_cell_valid     = r_cell_valid;
    assign o_direction      = r_dir;
    assign o_route_interval = r_interval;

    `D4FD_ASSERT_IMPLY(a_nodata_zero, i_clk, i_rst_n, r_done && !r_cell_valid, r_dir == d4fd_pkg::DIR_SELF && r_interval == '0, "nodata cell with nonzero result")
    `D4FD_ASSERT_IMPLY(a_dir_legal, i_clk, i_rst_n, r_done, r_dir <= d4fd_pkg::DIR_WEST, "direction code out of range")

endmodule

FILE: bench/d4_flow_direction_route_interval_core_test.sv
// Self-checking bench for the D4 flow direction and routing interval core.
// Depends on d4fd_pkg and the core; predicts each result and compares it per field.
`timescale 1ns / 1ps

module d4_flow_direction_route_interval_core_test;

    localparam int FB = d4fd_pkg::FRAC_BITS_DEF;
    localparam int LATENCY = 75 + 5 * FB;
    localparam longint CYCLE_LIMIT = 400000;

    typedef struct {
        logic                               valid;
        logic [d4fd_pkg::DIR_W-1:0]         dir;
        logic [d4fd_pkg::INTV_W-1:0]        interval;
    } t_flow;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [d4fd_pkg::ADDR_W-1:0] paddr = '0;
    logic [d4fd_pkg::DATA_W-1:0] pwdata = '0;
    logic [d4fd_pkg::DATA_W-1:0] prdata;
    logic pready;
    logic start = 1'b0;
    logic busy;
    logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_center = '0, i_elev_north = '0;
    logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_east = '0;
    logic signed [d4fd_pkg::ELEV_W-1:0] i_elev_south = '0, i_elev_west = '0;
    logic [d4fd_pkg::MASK_W-1:0] i_neighbor_mask = '0;
    logic i_center_nodata = 1'b0;
    logic [d4fd_pkg::SPACE_W-1:0] i_cell_dx = 24'd1, i_cell_dy = 24'd1;
    logic i_channel_present = 1'b0, i_boundary_hold = 1'b0;
    logic o_done, o_cell_valid;
    logic [d4fd_pkg::DIR_W-1:0] o_direction;
    logic [d4fd_pkg::INTV_W-1:0] o_route_interval;

    // Shadow copy of the register file.
    logic [d4fd_pkg::SPEED_W-1:0] speed_q;
    logic                         slope_q, latlong_q, subgrid_q;
    logic [d4fd_pkg::SPACE_W-1:0] grid_q;

    t_flow expected_flows[$];
    int    fail_count = 0;
    int    cells_sent = 0;
    int    flows_checked = 0;
    int    send_idle_pct = 0;
    longint cycle_count = 0;

    d4_flow_direction_route_interval_core u_dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .start, .busy, .i_elev_center, .i_elev_north, .i_elev_east, .i_elev_south,
        .i_elev_west, .i_neighbor_mask, .i_center_nodata, .i_cell_dx, .i_cell_dy,
        .i_channel_present, .i_boundary_hold, .o_done, .o_cell_valid, .o_direction,
        .o_route_interval
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [63:0] int_sqrt(input logic [63:0] x);
        logic [63:0] root, bitv;
        root = '0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x = x - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic logic [d4fd_pkg::INTV_W-1:0] travel_time(input logic [63:0] s,
                                                                input logic [63:0] drop);
        logic [63:0] v, q, r, den, t;
        v = 64'(speed_q);
        if (s == 0) return '0;
        if (!slope_q) begin
            if (v == 0) return d4fd_pkg::INTV_MAX;
            t = (s << FB) / v;
        end else begin
            q = (drop << (2 * FB)) / s;
            r = int_sqrt(q);
            den = v * r;
            if (den == 0) return d4fd_pkg::INTV_MAX;
            t = (s << (2 * FB)) / den;
        end
        return (t > 64'hFFFF_FFFF) ? d4fd_pkg::INTV_MAX : t[31:0];
    endfunction

    function automatic t_flow predict_flow();
        t_flow f;
        logic signed [d4fd_pkg::ELEV_W-1:0] elev[4];
        logic signed [d4fd_pkg::ELEV_W-1:0] lowest;
        logic [d4fd_pkg::DIR_W-1:0] dir;
        logic have;
        logic [63:0] sx, sy, s, drop;
        f.valid = 1'b0; f.dir = d4fd_pkg::DIR_SELF; f.interval = '0;
        if (i_center_nodata) return f;
        elev[0] = i_elev_north; elev[1] = i_elev_east;
        elev[2] = i_elev_south; elev[3] = i_elev_west;
        sx = latlong_q ? 64'(i_cell_dx) : 64'(grid_q);
        sy = latlong_q ? 64'(i_cell_dy) : 64'(grid_q);
        have = 1'b0; lowest = '0; dir = d4fd_pkg::DIR_SELF;
        for (int k = 0; k < 4; k++) begin
            if (i_neighbor_mask[k] && (!have || elev[k] < lowest)) begin
                lowest = elev[k];
                dir = d4fd_pkg::DIR_W'(k + 1);
                have = 1'b1;
            end
        end
        f.valid = 1'b1;
        if (have && lowest < i_elev_center) begin
            drop = 64'($signed(65'(i_elev_center) - 65'(lowest)));
            s = (dir == d4fd_pkg::DIR_NORTH || dir == d4fd_pkg::DIR_SOUTH) ? sy : sx;
            f.interval = travel_time(s, drop);
        end else begin
            dir = d4fd_pkg::DIR_SELF;
        end
        if ((subgrid_q && i_channel_present) || i_boundary_hold) dir = d4fd_pkg::DIR_SELF;
        f.dir = dir;
        return f;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            t_flow e;
            if (expected_flows.size() == 0) begin
                $error("unexpected result: no cell pending");
                fail_count++;
            end else begin
                e = expected_flows.pop_front();
                flows_checked++;
                if (o_cell_valid !== e.valid) begin
                    $error("cell_valid expected %0d actual %0d", e.valid, o_cell_valid);
                    fail_count++;
                end
                if (o_direction !== e.dir) begin
                    $error("direction expected %0d actual %0d", e.dir, o_direction);
                    fail_count++;
                end
                if (o_route_interval !== e.interval) begin
                    $error("route_interval expected %0d actual %0d",
                           e.interval, o_route_interval);
                    fail_count++;
                end
            end
        end
    end

    task automatic write_reg(input logic [d4fd_pkg::REG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= d4fd_pkg::ADDR_W'(idx) << 2; pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            d4fd_pkg::REG_SPEED:   speed_q = value[d4fd_pkg::SPEED_W-1:0];
            d4fd_pkg::REG_SLOPE:   slope_q = value[0];
            d4fd_pkg::REG_LATLONG: latlong_q = value[0];
            d4fd_pkg::REG_GRID:    grid_q = value[d4fd_pkg::SPACE_W-1:0];
            d4fd_pkg::REG_SUBGRID: subgrid_q = value[0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (expected_flows.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [d4fd_pkg::SPEED_W-1:0] v, input logic slope,
                             input logic ll, input logic [d4fd_pkg::SPACE_W-1:0] g,
                             input logic sg);
        wait_drained();
        write_reg(d4fd_pkg::REG_SPEED, 32'(v));
        write_reg(d4fd_pkg::REG_SLOPE, 32'(slope));
        write_reg(d4fd_pkg::REG_LATLONG, 32'(ll));
        write_reg(d4fd_pkg::REG_GRID, 32'(g));
        write_reg(d4fd_pkg::REG_SUBGRID, 32'(sg));
    endtask

    // Drives one cell request; it is assumed to be called at a falling edge.
    task automatic send_cell(input logic [31:0] c, n, e, s, w, input logic [3:0] m,
                             input logic nd, input logic [23:0] dx, dy,
                             input logic ch, bh);
        i_elev_center <= c; i_elev_north <= n; i_elev_east <= e;
        i_elev_south <= s; i_elev_west <= w; i_neighbor_mask <= m;
        i_center_nodata <= nd; i_cell_dx <= dx; i_cell_dy <= dy;
        i_channel_present <= ch; i_boundary_hold <= bh;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        expected_flows.push_back(predict_flow());
        cells_sent++;
        @(negedge i_clk);
        if ($urandom_range(99) < send_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(negedge i_clk);
        end
    endtask

    task automatic idle_start();
        start <= 1'b0;
    endtask

    function automatic logic [31:0] rand_elev();
        case ($urandom_range(3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(20000)) - 10000);
            2: return {$urandom_range(1) ? 32'h7FFF_FF00 : 32'h8000_0000} | $urandom_range(255);
            default: return 32'($signed($urandom_range(2000000)) - 1000000);
        endcase
    endfunction

    function automatic logic [23:0] rand_space();
        case ($urandom_range(3))
            0: return 24'($urandom) | 24'd1;
            1: return 24'($urandom_range(20000, 1));
            2: return 24'($urandom_range(1)) ? 24'hFFFFFF : 24'd1;
            default: return 24'($urandom_range(1 << 20, 1));
        endcase
    endfunction

    task automatic send_random();
        logic [31:0] c;
        c = rand_elev();
        send_cell(c, rand_elev(), rand_elev(), rand_elev(), rand_elev(),
                  4'($urandom), $urandom_range(15) == 0, rand_space(), rand_space(),
                  1'($urandom_range(1)), $urandom_range(7) == 0);
    endtask

    task automatic test_directed();
        logic [23:0] one, big;
        one = 24'd1; big = 24'hFFFFFF;
        // Steepest descent, with ties resolved in north, east, south, west order.
        send_cell(100, 50, 50, 50, 50, 4'hF, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 60, 40, 40, 90, 4'hF, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 60, 70, 30, 30, 4'hF, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 60, 70, 80, 10, 4'hF, 1'b0, one, one, 1'b0, 1'b0);
        // Lower neighbor masked out; flat cell; no valid neighbor.
        send_cell(100, 0, 200, 200, 200, 4'hE, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 100, 100, 100, 100, 4'hF, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 0, 0, 0, 0, 4'h0, 1'b0, one, one, 1'b0, 1'b0);
        // Elevation extremes.
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 4'h1, 1'b0, big, big, 1'b0, 1'b0);
        send_cell(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 4'h3, 1'b0, big, one, 1'b0, 1'b0);
        // Nodata, boundary hold and channel cells.
        send_cell(100, 0, 0, 0, 0, 4'hF, 1'b1, one, one, 1'b1, 1'b1);
        send_cell(100, 0, 0, 0, 0, 4'hF, 1'b0, one, one, 1'b0, 1'b1);
        send_cell(100, 0, 0, 0, 0, 4'hF, 1'b0, one, one, 1'b1, 1'b0);
        idle_start();
        configure(16'd1, 1'b0, 1'b1, 24'd1, 1'b1);
        send_cell(100, 0, 0, 0, 0, 4'hF, 1'b0, big, big, 1'b1, 1'b0);
        send_cell(100, 99, 0, 0, 0, 4'h1, 1'b0, big, big, 1'b0, 1'b0);
        send_cell(100, 200, 0, 200, 200, 4'hF, 1'b0, big, one, 1'b0, 1'b0);
        idle_start();
        configure(16'hFFFF, 1'b1, 1'b1, big, 1'b0);
        send_cell(100, 99, 0, 0, 0, 4'h1, 1'b0, big, big, 1'b0, 1'b0);
        send_cell(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0, 4'h1, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(100, 200, 0, 200, 200, 4'h2, 1'b0, one, one, 1'b0, 1'b0);
        send_cell(5000, 0, 0, 0, 0, 4'h8, 1'b0, one, 24'd3000, 1'b0, 1'b0);
        idle_start();
    endtask

    task automatic test_random_phase(input int count, input int idle_pct);
        send_idle_pct = idle_pct;
        for (int i = 0; i < count; i++) send_random();
        idle_start();
    endtask

    task automatic test_pause_drain();
        wait_drained();
        send_random();
        idle_start();
    endtask

    initial begin
        speed_q = d4fd_pkg::SPEED_RST; slope_q = 1'b0; latlong_q = 1'b0;
        grid_q = d4fd_pkg::GRID_RST; subgrid_q = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        configure(16'd102, 1'b0, 1'b0, 24'd10240, 1'b0);
        test_random_phase(160, 34);
        configure(16'($urandom_range(65535, 1)), 1'b1, 1'b1, 24'd10240, 1'b1);
        test_random_phase(160, 69);
        test_pause_drain();
        configure(16'd1, 1'b1, 1'b0, 24'hFFFFFF, 1'b0);
        test_random_phase(150, 0);
        configure(16'hFFFF, 1'b0, 1'b1, 24'd1, 1'b1);
        test_random_phase(150, 34);
        configure(16'($urandom_range(2000, 1)), 1'b1, 1'b0, 24'($urandom_range(50000, 1)),
                  1'b0);
        test_random_phase(150, 69);
        configure(16'($urandom_range(65535, 1)), 1'b0, 1'b0, 24'($urandom) | 24'd1, 1'b1);
        test_random_phase(150, 0);
        wait_drained();
        $display("Sent %0d cells across plain and slope routing, grid and per-cell spacing,",
                 cells_sent);
        $display("with and without sender gaps; checked %0d results.", flows_checked);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/d4fd_pkg.sv
rtl/d4fd_front.sv
rtl/d4fd_queue.sv
rtl/d4fd_div_pipe.sv
rtl/d4fd_sqrt_pipe.sv
rtl/d4fd_back.sv
rtl/d4_flow_direction_route_interval_core.sv
bench/d4_flow_direction_route_interval_core_test.sv
